// ===== design/sysex_reply_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the SysEx reply parser
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef SYSEX_REPLY_PARSER_CORE_MACROS_SVH
`define SYSEX_REPLY_PARSER_CORE_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define SRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srp assertion failed");

// Next-cycle implication, inactive while reset is asserted.
`define SRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srp assertion failed");

// Next-cycle implication that is also checked during reset.
`define SRP_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("srp reset assertion failed");

`endif

// ===== design/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// SysEx reply parser package
// Payload types, job descriptor, state encodings and protocol constants.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam logic [7:0] SYX_START   = 8'hF0;
  localparam logic [7:0] SYX_END     = 8'hF7;
  localparam logic [7:0] MFR_ID_0    = 8'h00;
  localparam logic [7:0] MFR_ID_1    = 8'h20;
  localparam logic [7:0] MFR_ID_2    = 8'h33;
  localparam logic [7:0] FN_PARAM    = 8'h01;
  localparam logic [7:0] FN_STRING   = 8'h03;
  localparam logic [7:0] PAR_ONOFF   = 8'h03;
  localparam logic [7:0] PAR_RIGNAME = 8'h01;
  localparam logic [7:0] PAGE_RIG    = 8'h00;
  localparam logic [6:0] CC_ON       = 7'd127;
  localparam logic [6:0] CC_OFF      = 7'd0;

  localparam int HDR_LEN  = 6;
  localparam int TEXT_OFS = 10;
  localparam int MIN_PARAM_LEN = 12;
  // Wide enough for any buffer length in the supported range.
  localparam int TXT_W = 7;

  localparam logic RK_CC   = 1'b0;
  localparam logic RK_NAME = 1'b1;

  typedef struct packed {
    logic [7:0] chunk_byte_0;
    logic [7:0] chunk_byte_1;
    logic [7:0] chunk_byte_2;
    logic [1:0] chunk_length;
    logic       message_end;
  } in_t;

  typedef struct packed {
    logic       result_kind;
    logic [6:0] cc_number;
    logic [6:0] cc_value;
    logic [4:0] name_length;
    logic [7:0] name_char;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic             is_name;
    logic [6:0]       cc;
    logic [6:0]       cc2;
    logic [6:0]       val;
    logic [TXT_W-1:0] txt_bytes;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] cc;
    logic [6:0] cc2;
  } page_hit_t;

  typedef enum logic [1:0] {F_IDLE, F_WR, F_END} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CC1, B_CC2, B_TRIM_RD, B_TRIM_CHK, B_DECIDE,
    B_CMP_RD, B_CMP_CHK, B_EMIT_RD, B_EMIT_OUT, B_CLR_OUT
  } back_state_t;

  // Module page to controller number table.
  function automatic page_hit_t page_lookup(input logic [7:0] page);
    page_hit_t r;
    r = '{hit: 1'b1, cc: 7'd0, cc2: 7'd0};
    case (page)
      8'h32:   r.cc = 7'd17;
      8'h33:   r.cc = 7'd18;
      8'h34:   r.cc = 7'd19;
      8'h35:   r.cc = 7'd20;
      8'h38:   r.cc = 7'd22;
      8'h3A:   begin r.cc = 7'd24; r.cc2 = 7'd25; end
      8'h3C:   begin r.cc = 7'd26; r.cc2 = 7'd27; end
      8'h3D:   begin r.cc = 7'd28; r.cc2 = 7'd29; end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/srp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/srp_front.sv =====
// ----------------------------------------------------------------------------
// SysEx reply parser front end
// Accepts chunks, assembles the message buffer and classifies finished messages.
// ----------------------------------------------------------------------------
module srp_front import srp_pkg::*; #(
  parameter int BUFFER_BYTES = 48,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int FW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          enabled,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          buf_we,
  output logic [AW-1:0] buf_waddr,
  output logic [7:0]    buf_wdata,
  output logic          q_push,
  output job_t          q_job,
  input  logic          q_full,
  input  logic          name_done
);

  front_state_t  st_r, st_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic          pend_r, pend_nxt;
  logic [FW-1:0] base_r, base_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  in_t           chunk_r, chunk_nxt;
  logic [7:0]    h0_r, h1_r, h2_r, h3_r, fn_r, page_r, par_r, onb_r;
  logic [7:0]    h0_nxt, h1_nxt, h2_nxt, h3_nxt, fn_nxt, page_nxt, par_nxt, onb_nxt;

  logic          accept, restart, over, hdr_ok, job_ok;
  logic [FW-1:0] base;
  logic [FW:0]   sum;
  logic [FW-1:0] wpos;
  page_hit_t     ph;

  assign in_stall = (st_r != F_IDLE) || pend_r;
  assign accept   = in_valid && !in_stall;
  assign wpos     = base_r + FW'(cnt_r);
  assign ph       = page_lookup(page_r);

  always_comb begin
    st_nxt = st_r; fill_nxt = fill_r; ovf_nxt = ovf_r; pend_nxt = pend_r;
    base_nxt = base_r; cnt_nxt = cnt_r; chunk_nxt = chunk_r;
    h0_nxt = h0_r; h1_nxt = h1_r; h2_nxt = h2_r; h3_nxt = h3_r;
    fn_nxt = fn_r; page_nxt = page_r; par_nxt = par_r; onb_nxt = onb_r;
    buf_we = 1'b0; buf_waddr = wpos[AW-1:0]; buf_wdata = chunk_r.chunk_byte_0;
    q_push = 1'b0; q_job = '0;
    restart = (fill_r != '0) && (in_data.chunk_length != 2'd0) &&
              (in_data.chunk_byte_0 == SYX_START);
    base = restart ? '0 : fill_r;
    sum  = {1'b0, base} + (FW + 1)'(in_data.chunk_length);
    over = sum > (FW + 1)'(BUFFER_BYTES);
    hdr_ok = !ovf_r && (fill_r >= FW'(TEXT_OFS)) && (fill_r > FW'(HDR_LEN)) &&
             (h0_r == SYX_START) && (h1_r == MFR_ID_0) &&
             (h2_r == MFR_ID_1) && (h3_r == MFR_ID_2);
    job_ok = 1'b0;
    if (hdr_ok) begin
      if (fn_r == FN_PARAM && fill_r >= FW'(MIN_PARAM_LEN)) begin
        if (par_r == PAR_ONOFF && ph.hit) begin
          job_ok = 1'b1;
          q_job.cc = ph.cc;
          q_job.cc2 = ph.cc2;
          q_job.val = (onb_r[6:0] != 7'd0) ? CC_ON : CC_OFF;
        end
      end else if (fn_r == FN_STRING && page_r == PAGE_RIG && par_r == PAR_RIGNAME) begin
        job_ok = 1'b1;
        q_job.is_name = 1'b1;
        q_job.txt_bytes = TXT_W'(fill_r) - TXT_W'(TEXT_OFS);
      end
    end

    if (name_done) pend_nxt = 1'b0;

    case (st_r)
      F_IDLE: begin
        if (accept) begin
          if (!enabled) begin
            fill_nxt = '0;
            ovf_nxt  = 1'b0;
          end else begin
            ovf_nxt = restart ? over : (ovf_r | over);
            fill_nxt = over ? base : sum[FW-1:0];
            base_nxt = base;
            chunk_nxt = in_data;
            cnt_nxt = 2'd0;
            if (!over && in_data.chunk_length != 2'd0) st_nxt = F_WR;
            else if (in_data.message_end) st_nxt = F_END;
          end
        end
      end
      F_WR: begin
        buf_we = 1'b1;
        case (cnt_r)
          2'd0:    buf_wdata = chunk_r.chunk_byte_0;
          2'd1:    buf_wdata = chunk_r.chunk_byte_1;
          default: buf_wdata = chunk_r.chunk_byte_2;
        endcase
        // Keep copies of the fixed-position bytes the classifier needs.
        case (wpos)
          FW'(0):  h0_nxt = buf_wdata;
          FW'(1):  h1_nxt = buf_wdata;
          FW'(2):  h2_nxt = buf_wdata;
          FW'(3):  h3_nxt = buf_wdata;
          FW'(6):  fn_nxt = buf_wdata;
          FW'(8):  page_nxt = buf_wdata;
          FW'(9):  par_nxt = buf_wdata;
          FW'(11): onb_nxt = buf_wdata;
          default: ;
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == chunk_r.chunk_length - 2'd1) begin
          st_nxt = chunk_r.message_end ? F_END : F_IDLE;
        end
      end
      F_END: begin
        if (!(job_ok && q_full)) begin
          q_push = job_ok;
          if (job_ok && q_job.is_name) pend_nxt = 1'b1;
          fill_nxt = '0;
          ovf_nxt = 1'b0;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      fill_r <= '0;
      ovf_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fill_r <= fill_nxt;
      ovf_r <= ovf_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt; cnt_r <= cnt_nxt; chunk_r <= chunk_nxt;
    h0_r <= h0_nxt; h1_r <= h1_nxt; h2_r <= h2_nxt; h3_r <= h3_nxt;
    fn_r <= fn_nxt; page_r <= page_nxt; par_r <= par_nxt; onb_r <= onb_nxt;
  end

endmodule

// ===== design/srp_queue.sv =====
// ----------------------------------------------------------------------------
// SysEx reply parser job queue
// Two-entry queue of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
module srp_queue import srp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_job;
  end

endmodule

// ===== design/srp_back.sv =====
// ----------------------------------------------------------------------------
// SysEx reply parser back end
// Executes queued jobs: control-change feedback and rig-name update.
// ----------------------------------------------------------------------------
module srp_back import srp_pkg::*; #(
  parameter int BUFFER_BYTES = 48,
  parameter int NAME_MAX = 20,
  localparam int AW  = $clog2(BUFFER_BYTES),
  localparam int NAW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1,
  localparam int LW  = $clog2(NAME_MAX + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  job_t          q_head,
  output logic          q_pop,
  output logic          buf_re,
  output logic [AW-1:0] buf_raddr,
  input  logic [7:0]    buf_rdata,
  output logic          name_done,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data
);

  back_state_t      st_r, st_nxt;
  job_t             job_r, job_nxt;
  logic [TXT_W-1:0] tl_r, tl_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    slen_r, slen_nxt;
  logic [LW-1:0]    idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  out_t             od_r, od_nxt;

  logic             out_free, last_idx;
  logic [LW-1:0]    len_calc;
  logic             nm_we, nm_re;
  logic [NAW-1:0]   nm_addr;
  logic [7:0]       nm_rdata;

  srp_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_name_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_addr),
    .wdata (buf_rdata),
    .re    (nm_re),
    .raddr (nm_addr),
    .rdata (nm_rdata)
  );

  assign out_free = !ov_r || !out_stall;
  assign last_idx = (LW'(idx_r + 1'b1) == len_r);
  assign len_calc = (tl_r > TXT_W'(NAME_MAX)) ? LW'(NAME_MAX) : LW'(tl_r);
  assign nm_addr  = idx_r[NAW-1:0];
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    st_nxt = st_r; job_nxt = job_r; tl_nxt = tl_r; len_nxt = len_r;
    slen_nxt = slen_r; idx_nxt = idx_r; od_nxt = od_r;
    ov_nxt = ov_r && out_stall;
    q_pop = 1'b0; buf_re = 1'b0; nm_re = 1'b0; nm_we = 1'b0; name_done = 1'b0;
    buf_raddr = AW'(TXT_W'(TEXT_OFS) + TXT_W'(idx_r));
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          job_nxt = q_head;
          tl_nxt = q_head.txt_bytes;
          st_nxt = q_head.is_name ? B_TRIM_RD : B_CC1;
        end
      end
      B_CC1: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '{result_kind: RK_CC, cc_number: job_r.cc, cc_value: job_r.val,
                     name_length: 5'd0, name_char: 8'd0,
                     last_of_run: (job_r.cc2 == 7'd0)};
          st_nxt = (job_r.cc2 == 7'd0) ? B_IDLE : B_CC2;
        end
      end
      B_CC2: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '{result_kind: RK_CC, cc_number: job_r.cc2, cc_value: job_r.val,
                     name_length: 5'd0, name_char: 8'd0, last_of_run: 1'b1};
          st_nxt = B_IDLE;
        end
      end
      B_TRIM_RD: begin
        if (tl_r == '0) begin
          st_nxt = B_DECIDE;
        end else begin
          buf_re = 1'b1;
          buf_raddr = AW'(TXT_W'(TEXT_OFS) + tl_r - TXT_W'(1));
          st_nxt = B_TRIM_CHK;
        end
      end
      B_TRIM_CHK: begin
        if (buf_rdata == SYX_END || buf_rdata == 8'h00) begin
          tl_nxt = tl_r - TXT_W'(1);
          st_nxt = B_TRIM_RD;
        end else begin
          st_nxt = B_DECIDE;
        end
      end
      B_DECIDE: begin
        len_nxt = len_calc;
        idx_nxt = '0;
        if (len_calc != slen_r) begin
          slen_nxt = len_calc;
          st_nxt = (len_calc == '0) ? B_CLR_OUT : B_EMIT_RD;
        end else if (len_calc == '0) begin
          name_done = 1'b1;
          st_nxt = B_IDLE;
        end else begin
          st_nxt = B_CMP_RD;
        end
      end
      B_CMP_RD: begin
        buf_re = 1'b1;
        nm_re = 1'b1;
        st_nxt = B_CMP_CHK;
      end
      B_CMP_CHK: begin
        if (buf_rdata != nm_rdata) begin
          idx_nxt = '0;
          st_nxt = B_EMIT_RD;
        end else if (last_idx) begin
          name_done = 1'b1;
          st_nxt = B_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt = B_CMP_RD;
        end
      end
      B_EMIT_RD: begin
        buf_re = 1'b1;
        st_nxt = B_EMIT_OUT;
      end
      B_EMIT_OUT: begin
        if (out_free) begin
          nm_we = 1'b1;
          ov_nxt = 1'b1;
          od_nxt = '{result_kind: RK_NAME, cc_number: 7'd0, cc_value: 7'd0,
                     name_length: 5'(len_r), name_char: buf_rdata,
                     last_of_run: last_idx};
          if (last_idx) begin
            name_done = 1'b1;
            st_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt = B_EMIT_RD;
          end
        end
      end
      B_CLR_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '{result_kind: RK_NAME, cc_number: 7'd0, cc_value: 7'd0,
                     name_length: 5'd0, name_char: 8'd0, last_of_run: 1'b1};
          name_done = 1'b1;
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      slen_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      slen_r <= slen_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt; tl_r <= tl_nxt; len_r <= len_nxt;
    idx_r <= idx_nxt; od_r <= od_nxt;
  end

endmodule

// ===== design/sysex_reply_parser_core.sv =====
// ----------------------------------------------------------------------------
// SysEx reply parser core
// Rebuilds System Exclusive replies from chunks and reports module state
// changes and rig-name updates.
// ----------------------------------------------------------------------------
// Usage: chunks of up to three bytes enter on the in_ channel (valid/stall);
// a transaction is taken when in_valid is high and in_stall is low. Results
// leave on the out_ channel in the same way, the last one of a message being
// flagged by last_of_run. cfg_wr_en writes the single enable bit; while it is
// clear every chunk just empties the buffer.
// Flow: a chunk is taken in the idle state, then its bytes are written one
// at a time to the message buffer (single write port); the chunk that ends
// a message also passes an end state, where the message is classified.
// Control-change results follow once the back end takes the job. A rig-name
// reply is trimmed of trailing bytes, compared with the stored name and only
// emitted if it differs; the input is held off until that job is finished.
// At reset the buffer, the stored name length and both channels are
// cleared; the memories themselves are not. A stalled receiver holds the
// output register, and the back end then stops, but the front end keeps
// taking chunks until its two-entry job queue is full.
// ----------------------------------------------------------------------------
module sysex_reply_parser_core import srp_pkg::*; #(
  parameter int BUFFER_BYTES = 48,
  parameter int NAME_MAX = 20
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW = $clog2(BUFFER_BYTES);

  // The enable bit; the user must write it only while the block is idle, the block itself does not enforce this.
  logic enabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enabled_r <= cfg_wr_data;
    end
  end

  // Message buffer: written by the front end, read by the back end. The
  // front end is held off while a name job is outstanding, so the two never
  // touch the buffer for different messages at once.
  logic          buf_we, buf_re;
  logic [AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]    buf_wdata, buf_rdata;

  logic q_push, q_full, q_pop, q_empty, name_done;
  job_t q_job, q_head;

  srp_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // Front end: assembles the message and classifies it at its end.
  srp_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .enabled   (enabled_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .buf_we    (buf_we),
    .buf_waddr (buf_waddr),
    .buf_wdata (buf_wdata),
    .q_push    (q_push),
    .q_job     (q_job),
    .q_full    (q_full),
    .name_done (name_done)
  );

  // Short queue of classified jobs.
  srp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Back end: runs the jobs and owns the output register and stored name.
  srp_back #(.BUFFER_BYTES(BUFFER_BYTES), .NAME_MAX(NAME_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .buf_re    (buf_re),
    .buf_raddr (buf_raddr),
    .buf_rdata (buf_rdata),
    .name_done (name_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/srp_checker.sv =====
// ----------------------------------------------------------------------------
// SysEx reply parser checker
// Port-level assertions, attached to the core by a bind statement.
// ----------------------------------------------------------------------------
`include "sysex_reply_parser_core_macros.svh"

module srp_checker import srp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `SRP_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid)
  `SRP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SRP_ASSERT_NOW(a_cc_shape, out_valid && out_data.result_kind == RK_CC, (out_data.cc_value == CC_ON || out_data.cc_value == CC_OFF) && out_data.name_length == 5'd0)
  `SRP_ASSERT_NOW(a_name_shape, out_valid && out_data.result_kind == RK_NAME, out_data.cc_number == 7'd0 && out_data.cc_value == 7'd0)

endmodule

bind sysex_reply_parser_core srp_checker u_srp_checker (.*);
